// ----- sv/vcl_pkg.sv -----
// ============================================================================
// vcl_pkg - shared constants, types and helpers of the command limiter
// Widths of the fixed-point components, the wide products and the register
// codes of the configuration port.
// ============================================================================
package vcl_pkg;

    localparam int COMP_WIDTH  = 32;
    localparam int FRAC_BITS   = 16;
    localparam int TIME_WIDTH  = 48;
    localparam int REG_WIDTH   = 32;
    localparam int SEQ_WIDTH   = 32;
    localparam int MODE_WIDTH  = 8;
    localparam int STAT_WIDTH  = 32;

    // magnitudes and differences need two guard bits over a component
    localparam int WIDE_WIDTH  = COMP_WIDTH + 2;
    localparam int PROD_WIDTH  = 2 * WIDE_WIDTH;
    localparam int MUL_WIDTH   = (WIDE_WIDTH > REG_WIDTH) ? WIDE_WIDTH : REG_WIDTH;
    localparam int LIMIT_WIDTH = 2 * REG_WIDTH - FRAC_BITS;
    localparam int CMP_WIDTH   = (LIMIT_WIDTH > WIDE_WIDTH) ? LIMIT_WIDTH : WIDE_WIDTH;
    localparam int ITER_WIDTH  = $clog2(WIDE_WIDTH + 1);

    localparam int CFG_IDX_WIDTH = 2;
    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        CFG_MAX_MAGNITUDE = 2'd0,
        CFG_MAX_RATE      = 2'd1,
        CFG_HOLD_TIMEOUT  = 2'd2
    } cfg_idx_t;

    typedef logic signed [WIDE_WIDTH-1:0] wide_t;

    function automatic logic [WIDE_WIDTH-1:0] mag_f(input wide_t v);
        logic [WIDE_WIDTH-1:0] r;
        begin
            r = v[WIDE_WIDTH-1] ? WIDE_WIDTH'(-v) : WIDE_WIDTH'(v);
            return r;
        end
    endfunction

    function automatic logic signed [COMP_WIDTH-1:0] sat_f(input wide_t v);
        wide_t hi;
        wide_t lo;
        begin
            hi = wide_t'({1'b0, {(COMP_WIDTH-1){1'b1}}});
            lo = -hi - wide_t'(1);
            if (v > hi)
                return COMP_WIDTH'(hi);
            else if (v < lo)
                return COMP_WIDTH'(lo);
            else
                return COMP_WIDTH'(v);
        end
    endfunction

endpackage

// ----- sv/vcl_if.sv -----
// ============================================================================
// vcl_if - request and result channels of the command limiter
// Valid/ready channels carrying one request or one result each.
// ============================================================================
interface vcl_in_if;
    import vcl_pkg::*;
    logic                         valid;
    logic                         ready;
    logic [SEQ_WIDTH-1:0]         seq_in;
    logic [TIME_WIDTH-1:0]        time_now;
    logic [REG_WIDTH-1:0]         step_time;
    logic [MODE_WIDTH-1:0]        mode_in;
    logic [STAT_WIDTH-1:0]        status_in;
    logic                         hold_request;
    logic signed [COMP_WIDTH-1:0] accel_x;
    logic signed [COMP_WIDTH-1:0] accel_y;
    logic signed [COMP_WIDTH-1:0] accel_z;

    modport source (output valid, seq_in, time_now, step_time, mode_in, status_in,
                    hold_request, accel_x, accel_y, accel_z, input ready);
    modport sink   (input valid, seq_in, time_now, step_time, mode_in, status_in,
                    hold_request, accel_x, accel_y, accel_z, output ready);
endinterface

interface vcl_out_if;
    import vcl_pkg::*;
    logic                         valid;
    logic                         ready;
    logic [SEQ_WIDTH-1:0]         seq_out;
    logic [TIME_WIDTH-1:0]        time_out;
    logic [MODE_WIDTH-1:0]        mode_out;
    logic signed [COMP_WIDTH-1:0] out_x;
    logic signed [COMP_WIDTH-1:0] out_y;
    logic signed [COMP_WIDTH-1:0] out_z;
    logic [STAT_WIDTH-1:0]        status_out;
    logic                         held_flag;
    logic                         magnitude_limited;
    logic                         rate_limited_flag;

    modport source (output valid, seq_out, time_out, mode_out, out_x, out_y, out_z,
                    status_out, held_flag, magnitude_limited, rate_limited_flag,
                    input ready);
    modport sink   (input valid, seq_out, time_out, mode_out, out_x, out_y, out_z,
                    status_out, held_flag, magnitude_limited, rate_limited_flag,
                    output ready);
endinterface

// ----- sv/vcl_mul.sv -----
// ============================================================================
// vcl_mul - shared registered multiplier
// Unsigned product of two operands, registered once.
// ============================================================================
module vcl_mul (
    input  logic                            clk,
    input  logic [vcl_pkg::MUL_WIDTH-1:0]   a,
    input  logic [vcl_pkg::MUL_WIDTH-1:0]   b,
    output logic [2*vcl_pkg::MUL_WIDTH-1:0] prod
);
    import vcl_pkg::*;

    logic [2*MUL_WIDTH-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;

endmodule

// ----- sv/vcl_sqrt.sv -----
// ============================================================================
// vcl_sqrt - iterative integer square root
// Floor square root, one root bit per cycle.
// ============================================================================
module vcl_sqrt (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [vcl_pkg::PROD_WIDTH-1:0]   radicand,
    output logic                             done,
    output logic [vcl_pkg::WIDE_WIDTH-1:0]   root
);
    import vcl_pkg::*;

    logic [PROD_WIDTH-1:0]   rad_reg;
    logic [WIDE_WIDTH:0]     rem_reg;
    logic [WIDE_WIDTH-1:0]   root_reg;
    logic [ITER_WIDTH-1:0]   cnt_reg;
    logic                    busy_reg;
    logic                    done_reg;
    logic [WIDE_WIDTH+2:0]   rem_sh;
    logic [WIDE_WIDTH+2:0]   trial;
    logic                    ge;

    assign rem_sh = {rem_reg, rad_reg[PROD_WIDTH-1 -: 2]};
    assign trial  = {1'b0, root_reg, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= ITER_WIDTH'(WIDE_WIDTH);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == ITER_WIDTH'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[PROD_WIDTH-3:0], 2'b00};
            rem_reg  <= ge ? (WIDE_WIDTH+1)'(rem_sh - trial) : (WIDE_WIDTH+1)'(rem_sh);
            root_reg <= {root_reg[WIDE_WIDTH-2:0], ge};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ----- sv/vcl_div.sv -----
// ============================================================================
// vcl_div - iterative restoring divider
// Quotient of a wide dividend by a divisor, one bit per cycle. The top half
// of the dividend must be below the divisor.
// ============================================================================
module vcl_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [vcl_pkg::PROD_WIDTH-1:0]   dividend,
    input  logic [vcl_pkg::WIDE_WIDTH-1:0]   divisor,
    output logic                             done,
    output logic [vcl_pkg::WIDE_WIDTH-1:0]   quotient
);
    import vcl_pkg::*;

    logic [WIDE_WIDTH-1:0] rem_reg;
    logic [WIDE_WIDTH-1:0] num_reg;
    logic [WIDE_WIDTH-1:0] den_reg;
    logic [WIDE_WIDTH-1:0] quo_reg;
    logic [ITER_WIDTH-1:0] cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic [WIDE_WIDTH:0]   rem_sh;
    logic                  ge;

    assign rem_sh = {rem_reg, num_reg[WIDE_WIDTH-1]};
    assign ge     = (rem_sh >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= ITER_WIDTH'(WIDE_WIDTH);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == ITER_WIDTH'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend[PROD_WIDTH-1:WIDE_WIDTH];
            num_reg <= dividend[WIDE_WIDTH-1:0];
            den_reg <= divisor;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? WIDE_WIDTH'(rem_sh - {1'b0, den_reg}) : WIDE_WIDTH'(rem_sh);
            num_reg <= {num_reg[WIDE_WIDTH-2:0], 1'b0};
            quo_reg <= {quo_reg[WIDE_WIDTH-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- sv/vector_command_limiter_unit.sv -----
// ============================================================================
// vector_command_limiter_unit - magnitude and slew limiter for a 3D command
// Sequencer around one shared multiplier, square root and divider.
// ============================================================================
// Usage:
//   in_ch  : one request per step (sequence, time, step time, mode, status,
//            hold request and a Q16.16 vector). Ready is high only while the
//            block is idle; a request is taken when valid and ready are high.
//   out_ch : one result per request, held in an output register until the
//            receiver takes it. A stalled receiver simply holds the block in
//            its output state; no further request is taken meanwhile.
//   cfg    : cfg_we writes cfg_data into register cfg_index (0 magnitude
//            limit, 1 change rate, 2 hold timeout); write only while idle.
// Sequence: each request runs the norm pass (squaring of the three
//   components, then the square root) and, when the limit is exceeded, three
//   scalings through the divider. With a non-zero step time the rate pass
//   repeats this on the change vector. The result is then offered; the next
//   request is taken only once the result has been handed over and the block
//   is back in idle. The divider and square root produce one bit per cycle.
// Reset: registers take their documented values, the stored vector and time
//   clear to zero and the block comes up idle.
// ============================================================================
module vector_command_limiter_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    vcl_in_if.sink                              in_ch,
    vcl_out_if.source                           out_ch,
    input  logic                                cfg_we,
    input  logic [vcl_pkg::CFG_IDX_WIDTH-1:0]   cfg_index,
    input  logic [vcl_pkg::REG_WIDTH-1:0]       cfg_data
);
    import vcl_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_SQ     = 11'b00000000010,
        S_ACC    = 11'b00000000100,
        S_SQRT   = 11'b00000001000,
        S_MUL    = 11'b00000010000,
        S_DSTART = 11'b00000100000,
        S_DIV    = 11'b00001000000,
        S_NEXT   = 11'b00010000000,
        S_RATE   = 11'b00100000000,
        S_DONE   = 11'b01000000000,
        S_OUT    = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [REG_WIDTH-1:0] max_mag_reg;
    logic [REG_WIDTH-1:0] max_rate_reg;
    logic [REG_WIDTH-1:0] hold_tmo_reg;

    // stored last command (a previous command always exists after reset)
    logic signed [COMP_WIDTH-1:0] last_x_reg, last_y_reg, last_z_reg;
    logic [TIME_WIDTH-1:0]        last_time_reg;

    // captured request
    logic [SEQ_WIDTH-1:0]  seq_reg;
    logic [TIME_WIDTH-1:0] time_reg;
    logic [REG_WIDTH-1:0]  dt_reg;
    logic [MODE_WIDTH-1:0] mode_reg;
    logic [STAT_WIDTH-1:0] stat_reg;
    logic                  hold_reg;

    // working vectors
    wide_t                 v_reg [3];
    wide_t                 w_reg [3];
    wide_t                 base_reg [3];
    logic [1:0]            idx_reg;
    logic                  pass_reg;
    logic [LIMIT_WIDTH-1:0] limit_reg;
    logic [PROD_WIDTH-1:0] acc_reg;
    logic                  mlim_reg;
    logic                  rlim_reg;

    // result register
    logic signed [COMP_WIDTH-1:0] ox_reg, oy_reg, oz_reg;

    // shared units
    logic [MUL_WIDTH-1:0]   mul_a, mul_b;
    logic [2*MUL_WIDTH-1:0] mul_p;
    logic                   sqrt_start, sqrt_done;
    logic [WIDE_WIDTH-1:0]  norm;
    logic                   div_start, div_done;
    logic [WIDE_WIDTH-1:0]  quo;

    logic                   in_acc, out_acc;
    logic                   stale;
    logic [TIME_WIDTH-1:0]  age;
    logic [WIDE_WIDTH-1:0]  w_mag;
    logic                   over;
    wide_t                  sres;

    assign in_acc  = in_ch.valid && in_ch.ready;
    assign out_acc = out_ch.valid && out_ch.ready;

    // drop a held vector that is too old or whose time ran backwards
    assign age   = in_ch.time_now - last_time_reg;
    assign stale = (in_ch.time_now < last_time_reg) ||
                   (age > TIME_WIDTH'(hold_tmo_reg));

    assign w_mag = mag_f(w_reg[idx_reg]);
    assign over  = (CMP_WIDTH'(norm) > CMP_WIDTH'(limit_reg));
    assign sres  = w_reg[idx_reg][WIDE_WIDTH-1] ? -wide_t'(quo) : wide_t'(quo);

    // operand select for the shared multiplier
    always_comb
    begin
        mul_a = MUL_WIDTH'(w_mag);
        mul_b = MUL_WIDTH'(w_mag);
        if (state_reg == S_MUL)
            mul_b = MUL_WIDTH'(limit_reg[WIDE_WIDTH-1:0]);
        else if (state_reg == S_NEXT)
        begin
            mul_a = MUL_WIDTH'(max_rate_reg);
            mul_b = MUL_WIDTH'(dt_reg);
        end
    end

    vcl_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (mul_p)
    );

    assign sqrt_start = (state_reg == S_ACC) && (idx_reg == 2'd2);

    vcl_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (acc_reg + mul_p[PROD_WIDTH-1:0]),
        .done     (sqrt_done),
        .root     (norm)
    );

    assign div_start = (state_reg == S_DSTART);

    vcl_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mul_p[PROD_WIDTH-1:0]),
        .divisor  (norm),
        .done     (div_done),
        .quotient (quo)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (in_acc) state_next = S_SQ;
            S_SQ:     state_next = S_ACC;
            S_ACC:    state_next = (idx_reg == 2'd2) ? S_SQRT : S_SQ;
            S_SQRT:   if (sqrt_done) state_next = over ? S_MUL : S_NEXT;
            S_MUL:    state_next = S_DSTART;
            S_DSTART: state_next = S_DIV;
            S_DIV:    if (div_done) state_next = (idx_reg == 2'd2) ? S_NEXT : S_MUL;
            S_NEXT:   state_next = (!pass_reg && dt_reg != '0) ? S_RATE : S_DONE;
            S_RATE:   state_next = S_SQ;
            S_DONE:   state_next = S_OUT;
            S_OUT:    if (out_acc) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            max_mag_reg   <= '1;
            max_rate_reg  <= '1;
            hold_tmo_reg  <= REG_WIDTH'(1) << FRAC_BITS;
            last_x_reg    <= '0;
            last_y_reg    <= '0;
            last_z_reg    <= '0;
            last_time_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_MAX_MAGNITUDE: max_mag_reg  <= cfg_data;
                    CFG_MAX_RATE:      max_rate_reg <= cfg_data;
                    CFG_HOLD_TIMEOUT:  hold_tmo_reg <= cfg_data;
                    default:           ;
                endcase
            end
            if (state_reg == S_DONE)
            begin
                last_x_reg    <= sat_f(v_reg[0]);
                last_y_reg    <= sat_f(v_reg[1]);
                last_z_reg    <= sat_f(v_reg[2]);
                last_time_reg <= time_reg;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    seq_reg   <= in_ch.seq_in;
                    time_reg  <= in_ch.time_now;
                    dt_reg    <= in_ch.step_time;
                    mode_reg  <= in_ch.mode_in;
                    stat_reg  <= in_ch.status_in;
                    hold_reg  <= in_ch.hold_request;
                    pass_reg  <= 1'b0;
                    idx_reg   <= 2'd0;
                    acc_reg   <= '0;
                    mlim_reg  <= 1'b0;
                    rlim_reg  <= 1'b0;
                    limit_reg <= LIMIT_WIDTH'(max_mag_reg);
                    for (int i = 0; i < 3; i++)
                        base_reg[i] <= '0;
                    if (in_ch.hold_request)
                    begin
                        v_reg[0] <= stale ? wide_t'(0) : wide_t'(last_x_reg);
                        v_reg[1] <= stale ? wide_t'(0) : wide_t'(last_y_reg);
                        v_reg[2] <= stale ? wide_t'(0) : wide_t'(last_z_reg);
                        w_reg[0] <= stale ? wide_t'(0) : wide_t'(last_x_reg);
                        w_reg[1] <= stale ? wide_t'(0) : wide_t'(last_y_reg);
                        w_reg[2] <= stale ? wide_t'(0) : wide_t'(last_z_reg);
                    end
                    else
                    begin
                        v_reg[0] <= wide_t'(in_ch.accel_x);
                        v_reg[1] <= wide_t'(in_ch.accel_y);
                        v_reg[2] <= wide_t'(in_ch.accel_z);
                        w_reg[0] <= wide_t'(in_ch.accel_x);
                        w_reg[1] <= wide_t'(in_ch.accel_y);
                        w_reg[2] <= wide_t'(in_ch.accel_z);
                    end
                end
            end
            S_ACC:
            begin
                acc_reg <= acc_reg + mul_p[PROD_WIDTH-1:0];
                if (idx_reg != 2'd2)
                    idx_reg <= idx_reg + 2'd1;
            end
            S_SQRT:
            begin
                if (sqrt_done)
                begin
                    idx_reg <= 2'd0;
                    if (over)
                    begin
                        if (pass_reg)
                            rlim_reg <= 1'b1;
                        else
                            mlim_reg <= 1'b1;
                    end
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    v_reg[idx_reg] <= base_reg[idx_reg] + sres;
                    idx_reg        <= idx_reg + 2'd1;
                end
            end
            S_RATE:
            begin
                // change vector against the stored command
                pass_reg    <= 1'b1;
                idx_reg     <= 2'd0;
                acc_reg     <= '0;
                limit_reg   <= mul_p[2*REG_WIDTH-1:FRAC_BITS];
                base_reg[0] <= wide_t'(last_x_reg);
                base_reg[1] <= wide_t'(last_y_reg);
                base_reg[2] <= wide_t'(last_z_reg);
                w_reg[0]    <= v_reg[0] - wide_t'(last_x_reg);
                w_reg[1]    <= v_reg[1] - wide_t'(last_y_reg);
                w_reg[2]    <= v_reg[2] - wide_t'(last_z_reg);
            end
            S_DONE:
            begin
                ox_reg <= sat_f(v_reg[0]);
                oy_reg <= sat_f(v_reg[1]);
                oz_reg <= sat_f(v_reg[2]);
            end
            default: ;
        endcase
    end

    assign in_ch.ready              = (state_reg == S_IDLE);
    assign out_ch.valid             = (state_reg == S_OUT);
    assign out_ch.seq_out           = seq_reg;
    assign out_ch.time_out          = time_reg;
    assign out_ch.mode_out          = mode_reg;
    assign out_ch.out_x             = ox_reg;
    assign out_ch.out_y             = oy_reg;
    assign out_ch.out_z             = oz_reg;
    assign out_ch.status_out        = stat_reg;
    assign out_ch.held_flag         = hold_reg;
    assign out_ch.magnitude_limited = mlim_reg;
    assign out_ch.rate_limited_flag = rlim_reg;

    // a request and a pending result never coexist
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ch.ready && out_ch.valid))
        else $error("ready while result pending");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !in_ch.ready)
        else $error("ready straight after accepting a request");

    a_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc |=> in_ch.ready)
        else $error("not ready after result taken");

    a_units: assert property (@(posedge clk) disable iff (!rst_n)
        !(sqrt_start && div_start))
        else $error("square root and divider started together");

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// ============================================================================
// testbench - regression for vector_command_limiter_unit
// Random and directed command requests go through the limiter. An internal
// predictor of the magnitude and slew limits checks every result field.
// The configuration is changed between phases, only while the block is idle.
// ============================================================================
module testbench;
    import vcl_pkg::*;

    typedef struct {
        logic [SEQ_WIDTH-1:0]         seq;
        logic [TIME_WIDTH-1:0]        stamp;
        logic [REG_WIDTH-1:0]         step;
        logic [MODE_WIDTH-1:0]        mode;
        logic [STAT_WIDTH-1:0]        status;
        logic                         hold;
        logic signed [COMP_WIDTH-1:0] ax;
        logic signed [COMP_WIDTH-1:0] ay;
        logic signed [COMP_WIDTH-1:0] az;
    } command_t;

    typedef struct {
        logic [SEQ_WIDTH-1:0]         seq;
        logic [TIME_WIDTH-1:0]        stamp;
        logic [MODE_WIDTH-1:0]        mode;
        logic signed [COMP_WIDTH-1:0] ox;
        logic signed [COMP_WIDTH-1:0] oy;
        logic signed [COMP_WIDTH-1:0] oz;
        logic [STAT_WIDTH-1:0]        status;
        logic                         held;
        logic                         mag_lim;
        logic                         rate_lim;
    } limited_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_WIDTH-1:0] cfg_index;
    logic [REG_WIDTH-1:0]     cfg_data;

    vcl_in_if  in_ch();
    vcl_out_if out_ch();

    vector_command_limiter_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // pending requests and the results they should produce
    command_t pending_cmds[$];
    limited_t expected_cmds[$];
    int       error_count = 0;

    // idle percentages of each side, set per phase
    int send_idle_pct = 25;
    int recv_idle_pct = 64;

    // long receiver hold-off: asked by the stimulus, counted by the monitor
    int hold_off_asked = 0;
    int hold_off_taken = 0;
    int hold_off_left  = 0;

    // predictor copy of the registers and stored command
    logic [63:0] lim_magnitude;
    logic [63:0] lim_rate;
    logic [63:0] lim_timeout;
    longint      prev_x, prev_y, prev_z;
    logic [63:0] prev_stamp;

    // time base of the random generator
    logic [TIME_WIDTH-1:0] gen_stamp = '0;

    // ------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_MAX_MAGNITUDE;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.seq_in = '0;
        in_ch.time_now = '0;
        in_ch.step_time = '0;
        in_ch.mode_in = '0;
        in_ch.status_in = '0;
        in_ch.hold_request = 1'b0;
        in_ch.accel_x = '0;
        in_ch.accel_y = '0;
        in_ch.accel_z = '0;
        out_ch.ready = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Predictor arithmetic: exact norms and truncating scaling
    // ------------------------------------------------------------------
    function automatic logic [63:0] abs_of(longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic [63:0] vector_norm(longint a, longint b, longint c);
        logic [127:0] sum;
        logic [63:0]  root;
        logic [63:0]  trial;
        sum = 128'(abs_of(a)) * 128'(abs_of(a)) + 128'(abs_of(b)) * 128'(abs_of(b))
            + 128'(abs_of(c)) * 128'(abs_of(c));
        root = '0;
        for (int bit_pos = 63; bit_pos >= 0; bit_pos--)
        begin
            trial = root | (64'd1 << bit_pos);
            if (128'(trial) * 128'(trial) <= sum)
                root = trial;
        end
        return root;
    endfunction

    function automatic longint scale_toward_zero(longint c, logic [63:0] num,
                                                 logic [63:0] den);
        logic [127:0] q;
        q = (128'(abs_of(c)) * 128'(num)) / 128'(den);
        return c < 0 ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    function automatic longint clip_component(longint v);
        longint top;
        top = (longint'(1) <<< (COMP_WIDTH - 1)) - 1;
        return v > top ? top : (v < -top - 1 ? -top - 1 : v);
    endfunction

    // Work out the limited command and advance the stored state
    function automatic limited_t limit_command(command_t c);
        limited_t    r;
        longint      v[3];
        longint      d[3];
        longint      p[3];
        logic [63:0] n;
        logic [63:0] allowed;
        logic [127:0] prod;
        r.seq = c.seq;
        r.stamp = c.stamp;
        r.mode = c.mode;
        r.status = c.status;
        r.held = c.hold;
        r.mag_lim = 1'b0;
        r.rate_lim = 1'b0;
        p[0] = prev_x; p[1] = prev_y; p[2] = prev_z;
        if (c.hold)
        begin
            v = p;
            // stale or time ran backwards: drop the held vector
            if (64'(c.stamp) < prev_stamp || 64'(c.stamp) - prev_stamp > lim_timeout)
                v = '{0, 0, 0};
        end
        else
        begin
            v[0] = c.ax; v[1] = c.ay; v[2] = c.az;
        end
        n = vector_norm(v[0], v[1], v[2]);
        if (n > lim_magnitude)
        begin
            r.mag_lim = 1'b1;
            for (int i = 0; i < 3; i++)
                v[i] = scale_toward_zero(v[i], lim_magnitude, n);
        end
        // zero step time skips the slew limit
        if (c.step != 0)
        begin
            prod = 128'(lim_rate) * 128'(c.step);
            allowed = 64'(prod >> FRAC_BITS);
            for (int i = 0; i < 3; i++)
                d[i] = v[i] - p[i];
            n = vector_norm(d[0], d[1], d[2]);
            if (n > allowed)
            begin
                r.rate_lim = 1'b1;
                for (int i = 0; i < 3; i++)
                    v[i] = p[i] + scale_toward_zero(d[i], allowed, n);
            end
        end
        for (int i = 0; i < 3; i++)
            v[i] = clip_component(v[i]);
        prev_x = v[0]; prev_y = v[1]; prev_z = v[2];
        prev_stamp = 64'(c.stamp);
        r.ox = COMP_WIDTH'(v[0]);
        r.oy = COMP_WIDTH'(v[1]);
        r.oz = COMP_WIDTH'(v[2]);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Driver: offer pending requests, predict each one on acceptance
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        command_t nxt;
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
                expected_cmds.push_back(limit_command('{in_ch.seq_in, in_ch.time_now,
                    in_ch.step_time, in_ch.mode_in, in_ch.status_in, in_ch.hold_request,
                    in_ch.accel_x, in_ch.accel_y, in_ch.accel_z}));
            // hold an unaccepted request, otherwise advance or idle
            if (in_ch.valid && !in_ch.ready)
                ;
            else if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                nxt = pending_cmds.pop_front();
                in_ch.valid <= 1'b1;
                in_ch.seq_in <= nxt.seq;
                in_ch.time_now <= nxt.stamp;
                in_ch.step_time <= nxt.step;
                in_ch.mode_in <= nxt.mode;
                in_ch.status_in <= nxt.status;
                in_ch.hold_request <= nxt.hold;
                in_ch.accel_x <= nxt.ax;
                in_ch.accel_y <= nxt.ay;
                in_ch.accel_z <= nxt.az;
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check each result against the oldest expectation
    // ------------------------------------------------------------------
    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: mismatch on %s: expected %h, actual %h", $time, name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        limited_t e;
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_cmds.size() == 0)
                begin
                    $display("%0t: result with no request outstanding, seq %h",
                             $time, out_ch.seq_out);
                    error_count++;
                end
                else
                begin
                    e = expected_cmds.pop_front();
                    check_field("seq_out", 64'(e.seq), 64'(out_ch.seq_out));
                    check_field("time_out", 64'(e.stamp), 64'(out_ch.time_out));
                    check_field("mode_out", 64'(e.mode), 64'(out_ch.mode_out));
                    check_field("out_x", 64'(e.ox), 64'(out_ch.out_x));
                    check_field("out_y", 64'(e.oy), 64'(out_ch.out_y));
                    check_field("out_z", 64'(e.oz), 64'(out_ch.out_z));
                    check_field("status_out", 64'(e.status), 64'(out_ch.status_out));
                    check_field("held_flag", 64'(e.held), 64'(out_ch.held_flag));
                    check_field("magnitude_limited", 64'(e.mag_lim),
                                64'(out_ch.magnitude_limited));
                    check_field("rate_limited_flag", 64'(e.rate_lim),
                                64'(out_ch.rate_limited_flag));
                end
            end
            // long hold-off first, then random stalls
            if (hold_off_left > 0)
            begin
                hold_off_left <= hold_off_left - 1;
                out_ch.ready <= 1'b0;
            end
            else if (hold_off_asked != hold_off_taken)
            begin
                hold_off_taken <= hold_off_asked;
                hold_off_left <= 600;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= $urandom_range(99) >= recv_idle_pct;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic write_reg(cfg_idx_t idx, logic [REG_WIDTH-1:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            CFG_MAX_MAGNITUDE: lim_magnitude = 64'(value);
            CFG_MAX_RATE:      lim_rate = 64'(value);
            default:           lim_timeout = 64'(value);
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_limits(logic [31:0] magnitude, logic [31:0] rate, logic [31:0] timeout);
        write_reg(CFG_MAX_MAGNITUDE, magnitude);
        write_reg(CFG_MAX_RATE, rate);
        write_reg(CFG_HOLD_TIMEOUT, timeout);
    endtask

    // Pause the sender until every result is back, then let the block settle;
    // sample on the falling edge so the driver's updates have all landed
    task automatic drain_all();
        while (pending_cmds.size() > 0 || in_ch.valid || expected_cmds.size() > 0)
            @(negedge clk);
        repeat (400) @(posedge clk);
    endtask

    task automatic add_cmd(logic [47:0] stamp, logic [31:0] step, logic hold,
                           logic [31:0] ax, logic [31:0] ay, logic [31:0] az);
        pending_cmds.push_back('{$urandom, stamp, step, 8'($urandom), $urandom, hold,
                                 ax, ay, az});
    endtask

    function automatic logic [31:0] rand_component();
        case ($urandom_range(5))
            0: return $urandom;
            1: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            2: return '0;
            default: return 32'($signed($urandom_range(32'h80000)) - 32'sh40000);
        endcase
    endfunction

    // Mostly well-formed steps with time going forward, some jumps and reversals
    task automatic queue_random(int count);
        logic [31:0] step;
        for (int k = 0; k < count; k++)
        begin
            case ($urandom_range(19))
                0:       gen_stamp = 48'({$urandom, $urandom});
                1:       gen_stamp = gen_stamp - 48'($urandom_range(32'h10000));
                2:       gen_stamp = gen_stamp + 48'($urandom_range(32'h40000));
                default: gen_stamp = gen_stamp + 48'($urandom_range(32'h2000));
            endcase
            case ($urandom_range(9))
                0, 1:    step = '0;
                2:       step = $urandom;
                default: step = $urandom_range(32'h1000);
            endcase
            add_cmd(gen_stamp, step, $urandom_range(99) < 30,
                    rand_component(), rand_component(), rand_component());
        end
    endtask

    // ------------------------------------------------------------------
    // Phases
    // ------------------------------------------------------------------
    initial
    begin
        lim_magnitude = 64'hFFFF_FFFF;
        lim_rate = 64'hFFFF_FFFF;
        lim_timeout = 64'd65536;
        prev_x = 0; prev_y = 0; prev_z = 0;
        prev_stamp = '0;
        @(posedge rst_n);

        // Directed: reset limits, field extremes, hold corner cases
        add_cmd(48'd0, 32'd0, 1'b0, 32'd0, 32'd0, 32'd0);
        add_cmd(48'd10, 32'd0, 1'b1, 32'd0, 32'd0, 32'd0);
        add_cmd(48'd20, 32'd0, 1'b0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        add_cmd(48'd30, 32'd0, 1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_cmd(48'd40, 32'd0, 1'b1, 32'hFFFF_FFFF, 32'h1234_5678, 32'h0);
        add_cmd(48'd40 + 48'd65536, 32'd0, 1'b1, 32'h0, 32'h0, 32'h0);
        add_cmd(48'd40 + 48'd131073, 32'd0, 1'b1, 32'h0, 32'h0, 32'h0);
        add_cmd(48'd200000, 32'd0, 1'b0, 32'h0003_0000, 32'hFFFC_0000, 32'h0001_0000);
        add_cmd(48'd100, 32'd0, 1'b1, 32'h0, 32'h0, 32'h0);
        add_cmd(48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'h8000_0000, 32'h7FFF_FFFF,
                32'h8000_0000);
        add_cmd(48'hFFFF_FFFF_FFFF, 32'd1, 1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
        add_cmd(48'd5, 32'd1, 1'b1, 32'h0, 32'h0, 32'h0);
        add_cmd(48'd6, 32'd0, 1'b0, 32'h0001_0000, 32'h0, 32'h0);
        pending_cmds.push_back('{32'hFFFF_FFFF, 48'd7, 32'd0, 8'hFF, 32'hFFFF_FFFF, 1'b1,
                                 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
        pending_cmds.push_back('{32'h0, 48'd8, 32'd0, 8'h00, 32'h0, 1'b0,
                                 32'h0, 32'h0, 32'h0});
        drain_all();

        // Tight limits: magnitude and slew both bite
        set_limits(32'h0003_0000, 32'h0002_0000, 32'h0000_8000);
        add_cmd(48'd1000, 32'h0001_0000, 1'b0, 32'h0010_0000, 32'h0, 32'h0);
        add_cmd(48'd2000, 32'h0000_0100, 1'b0, 32'hFFF0_0000, 32'h0008_0000, 32'h1);
        add_cmd(48'd2100, 32'h0000_0100, 1'b1, 32'h0, 32'h0, 32'h0);
        queue_random(150);
        drain_all();

        // Zero limits, sides swapped
        send_idle_pct = 64;
        recv_idle_pct = 25;
        set_limits(32'h0, 32'h0, 32'h0);
        queue_random(100);
        drain_all();

        // Widest limits; receiver holds off while the sender keeps offering
        set_limits(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_random(150);
        hold_off_asked++;
        drain_all();

        // Random limits, no idling on either side
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int ph = 0; ph < 4; ph++)
        begin
            set_limits($urandom_range(32'h0010_0000), $urandom_range(1) ? $urandom
                       : $urandom_range(32'h0008_0000), $urandom_range(32'h0004_0000));
            queue_random(90);
            drain_all();
        end

        if (error_count == 0)
            $display("vector_command_limiter_unit regression: pass");
        else
            $display("vector_command_limiter_unit regression: fail");
        $finish;
    end

    // Watchdog
    initial
    begin
        #30ms;
        $display("vector_command_limiter_unit regression: fail");
        $finish;
    end

endmodule
